@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the video register and scroll unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define VRSU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define VRSU_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/vrsu_pkg.sv @@
// Types and constants of the video register and scroll unit.
package vrsu_pkg;

   localparam logic [3:0] CMD_REG_READ      = 4'd0;
   localparam logic [3:0] CMD_REG_WRITE     = 4'd1;
   localparam logic [3:0] CMD_COARSE_X_INC  = 4'd2;
   localparam logic [3:0] CMD_Y_INC         = 4'd3;
   localparam logic [3:0] CMD_COPY_HORIZ    = 4'd4;
   localparam logic [3:0] CMD_COPY_VERT     = 4'd5;
   localparam logic [3:0] CMD_VBLANK_START  = 4'd6;
   localparam logic [3:0] CMD_PRERENDER_CLR = 4'd7;
   localparam logic [3:0] CMD_SPRITE0_HIT   = 4'd8;

   localparam logic [2:0] REG_CTRL        = 3'd0;
   localparam logic [2:0] REG_MASK        = 3'd1;
   localparam logic [2:0] REG_STATUS      = 3'd2;
   localparam logic [2:0] REG_SPRITE_ADDR = 3'd3;
   localparam logic [2:0] REG_SPRITE_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL      = 3'd5;
   localparam logic [2:0] REG_ADDR        = 3'd6;
   localparam logic [2:0] REG_DATA        = 3'd7;

   localparam logic [15:0] MASK_NT_SELECT  = 16'hF3FF;
   localparam logic [15:0] MASK_SCROLL_Y   = 16'h8C1F;
   localparam logic [15:0] MASK_COARSE_X   = 16'hFFE0;
   localparam logic [15:0] MASK_ADDR_HIGH  = 16'h80FF;
   localparam logic [15:0] MASK_HORIZ_KEEP = 16'hFBE0;
   localparam logic [15:0] MASK_HORIZ_COPY = 16'h041F;
   localparam logic [15:0] MASK_VERT_KEEP  = 16'h841F;
   localparam logic [15:0] MASK_VERT_COPY  = 16'h7BE0;
   localparam logic [15:0] MASK_FINE_Y     = 16'h7000;
   localparam logic [15:0] MASK_FINE_Y_CLR = 16'h8FFF;
   localparam logic [15:0] MASK_COARSE_Y   = 16'h03E0;
   localparam logic [15:0] MASK_COARSE_Y_CLR = 16'hFC1F;
   localparam logic [15:0] FLIP_NT_HORIZ   = 16'h0400;
   localparam logic [15:0] FLIP_NT_VERT    = 16'h0800;
   localparam logic [15:0] FINE_Y_STEP     = 16'h1000;
   localparam logic [13:0] PALETTE_BASE    = 14'h3F00;

   localparam int STATUS_SPRITE0_BIT = 1;
   localparam int STATUS_VBLANK_BIT  = 2;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        nmi_pulse;
      logic [13:0] mem_addr;
      logic        mem_read_strobe;
      logic        mem_write_strobe;
      logic [15:0] scroll_addr;
      logic [2:0]  fine_scroll_x;
      logic [7:0]  control_byte;
      logic [7:0]  mask_byte;
      logic        sprite_read;
   } vrsu_result_type;

   typedef struct packed {
      logic s1_valid;
      logic out_valid;
   } vrsu_pipe_status_type;

endpackage

@@ rtl/core/vrsu_sprite_ram.sv @@
// Sprite memory: one synchronous port pair with per-entry valid bits.
module vrsu_sprite_ram
   import vrsu_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   output logic [7:0]               rd_data
);

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [7:0]       rd_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff     <= mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_vld_ff ? rd_ff : 8'd0;

endmodule

@@ rtl/core/vrsu_reg_file.sv @@
// Register file and scroll-address update; state changes at the accepting edge.
module vrsu_reg_file
   import vrsu_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [3:0]               command,
   input  logic [2:0]               reg_index,
   input  logic [7:0]               write_data,
   input  logic [7:0]               mem_data,
   output vrsu_result_type          result,
   output logic                     spr_rd_en,
   output logic                     spr_wr_en,
   output logic [$clog2(DEPTH)-1:0] spr_addr
);

   logic [15:0] cur_ff, cur_in;
   logic [15:0] temp_ff, temp_in;
   logic [2:0]  fine_ff, fine_in;
   logic        toggle_ff, toggle_in;
   logic [7:0]  rbuf_ff, rbuf_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  spr_ff, spr_in;

   logic        render_on;
   logic [15:0] port_next;
   logic [15:0] coarse_x_next;
   logic [15:0] y_next;
   logic [15:0] y_wrap;
   logic [4:0]  coarse_y;
   logic [15:0] addr_low;

   assign render_on = mask_ff[3] | mask_ff[4];
   assign port_next = cur_ff + (ctrl_ff[2] ? 16'd32 : 16'd1);
   assign addr_low  = (temp_ff & 16'hFF00) | {8'd0, write_data};

   always_comb begin
      if (cur_ff[4:0] == 5'd31) begin
         coarse_x_next = (cur_ff & MASK_COARSE_X) ^ FLIP_NT_HORIZ;
      end else begin
         coarse_x_next = cur_ff + 16'd1;
      end
   end

   // Fine Y rolls into coarse Y; row 29 flips the vertical nametable.
   always_comb begin
      y_wrap   = cur_ff & MASK_FINE_Y_CLR;
      coarse_y = y_wrap[9:5];
      if (coarse_y == 5'd29) begin
         coarse_y = 5'd0;
         y_wrap   = y_wrap ^ FLIP_NT_VERT;
      end else if (coarse_y == 5'd31) begin
         coarse_y = 5'd0;
      end else begin
         coarse_y = coarse_y + 5'd1;
      end
      if ((cur_ff & MASK_FINE_Y) != MASK_FINE_Y) begin
         y_next = cur_ff + FINE_Y_STEP;
      end else begin
         y_next = (y_wrap & MASK_COARSE_Y_CLR) | {6'd0, coarse_y, 5'd0};
      end
   end

   always_comb begin
      cur_in    = cur_ff;
      temp_in   = temp_ff;
      fine_in   = fine_ff;
      toggle_in = toggle_ff;
      rbuf_in   = rbuf_ff;
      ctrl_in   = ctrl_ff;
      mask_in   = mask_ff;
      status_in = status_ff;
      spr_in    = spr_ff;
      spr_rd_en = 1'b0;
      spr_wr_en = 1'b0;
      result    = '0;
      case (command)
         CMD_REG_READ: begin
            case (reg_index)
               REG_STATUS: begin
                  result.read_data = {status_ff, 5'd0};
                  status_in[STATUS_VBLANK_BIT] = 1'b0;
                  toggle_in = 1'b0;
               end
               REG_SPRITE_DATA: begin
                  spr_rd_en = 1'b1;
                  result.sprite_read = 1'b1;
               end
               REG_DATA: begin
                  result.mem_addr = cur_ff[13:0];
                  result.mem_read_strobe = 1'b1;
                  cur_in = port_next;
                  rbuf_in = mem_data;
                  result.read_data = (cur_ff[13:0] < PALETTE_BASE) ? rbuf_ff : mem_data;
               end
               default: begin
               end
            endcase
         end
         CMD_REG_WRITE: begin
            case (reg_index)
               REG_CTRL: begin
                  result.nmi_pulse = ~ctrl_ff[7] & write_data[7]
                                     & status_ff[STATUS_VBLANK_BIT];
                  ctrl_in = write_data;
                  temp_in = (temp_ff & MASK_NT_SELECT) | {4'd0, write_data[1:0], 10'd0};
               end
               REG_MASK: begin
                  mask_in = write_data;
               end
               REG_SPRITE_ADDR: begin
                  spr_in = write_data;
               end
               REG_SPRITE_DATA: begin
                  spr_wr_en = 1'b1;
                  spr_in = spr_ff + 8'd1;
               end
               REG_SCROLL: begin
                  if (toggle_ff) begin
                     temp_in = (temp_ff & MASK_SCROLL_Y)
                               | {1'b0, write_data[2:0], 2'd0, write_data[7:3], 5'd0};
                  end else begin
                     temp_in = (temp_ff & MASK_COARSE_X) | {11'd0, write_data[7:3]};
                     fine_in = write_data[2:0];
                  end
                  toggle_in = ~toggle_ff;
               end
               REG_ADDR: begin
                  if (toggle_ff) begin
                     temp_in = addr_low;
                     cur_in  = addr_low;
                  end else begin
                     temp_in = (temp_ff & MASK_ADDR_HIGH) | {2'd0, write_data[5:0], 8'd0};
                  end
                  toggle_in = ~toggle_ff;
               end
               REG_DATA: begin
                  result.mem_addr = cur_ff[13:0];
                  result.mem_write_strobe = 1'b1;
                  cur_in = port_next;
               end
               default: begin
               end
            endcase
         end
         CMD_COARSE_X_INC: begin
            if (render_on) cur_in = coarse_x_next;
         end
         CMD_Y_INC: begin
            if (render_on) cur_in = y_next;
         end
         CMD_COPY_HORIZ: begin
            if (render_on) cur_in = (cur_ff & MASK_HORIZ_KEEP) | (temp_ff & MASK_HORIZ_COPY);
         end
         CMD_COPY_VERT: begin
            if (render_on) cur_in = (cur_ff & MASK_VERT_KEEP) | (temp_ff & MASK_VERT_COPY);
         end
         CMD_VBLANK_START: begin
            status_in[STATUS_VBLANK_BIT] = 1'b1;
            result.nmi_pulse = ctrl_ff[7];
         end
         CMD_PRERENDER_CLR: begin
            status_in = 3'd0;
         end
         CMD_SPRITE0_HIT: begin
            status_in[STATUS_SPRITE0_BIT] = 1'b1;
         end
         default: begin
         end
      endcase
      spr_rd_en = spr_rd_en & fire;
      spr_wr_en = spr_wr_en & fire;
      result.scroll_addr   = cur_in;
      result.fine_scroll_x = fine_in;
      result.control_byte  = ctrl_in;
      result.mask_byte     = mask_in;
   end

   assign spr_addr = spr_ff[$clog2(DEPTH)-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         temp_ff   <= '0;
         fine_ff   <= '0;
         toggle_ff <= 1'b0;
         rbuf_ff   <= '0;
         ctrl_ff   <= '0;
         mask_ff   <= '0;
         status_ff <= '0;
         spr_ff    <= '0;
      end else if (fire) begin
         cur_ff    <= cur_in;
         temp_ff   <= temp_in;
         fine_ff   <= fine_in;
         toggle_ff <= toggle_in;
         rbuf_ff   <= rbuf_in;
         ctrl_ff   <= ctrl_in;
         mask_ff   <= mask_in;
         status_ff <= status_in;
         spr_ff    <= spr_in;
      end
   end

endmodule

@@ rtl/core/vrsu_rsp_pipe.sv @@
// Memory-read stage and output register of the result channel.
module vrsu_rsp_pipe
   import vrsu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  vrsu_result_type      result,
   input  logic [7:0]           spr_rd_data,
   output logic                 in_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,
   output vrsu_pipe_status_type status
);

   vrsu_result_type s1_ff;
   logic            s1_valid_ff, s1_valid_in;
   vrsu_result_type out_ff, out_in;
   logic            out_valid_ff, out_valid_in;
   logic            s1_move;

   // The sprite memory output holds while the first stage waits, since no
   // new read is issued until that stage moves on.
   assign s1_move  = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign in_ready = ~s1_valid_ff | s1_move;

   assign s1_valid_in  = fire | (s1_valid_ff & ~s1_move);
   assign out_valid_in = s1_move | (out_valid_ff & ~rsp_tready);

   always_comb begin
      out_in = s1_ff;
      if (s1_ff.sprite_read) begin
         out_in.read_data = spr_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_ff <= result;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.mask_byte, out_ff.control_byte, out_ff.fine_scroll_x,
                        out_ff.scroll_addr, out_ff.mem_write_strobe, out_ff.mem_read_strobe,
                        out_ff.mem_addr, out_ff.nmi_pulse, out_ff.read_data};
   assign status.s1_valid  = s1_valid_ff;
   assign status.out_valid = out_valid_ff;

endmodule

@@ rtl/core/video_register_scroll_unit_top.sv @@
// Video register file and scroll-address unit, top level.
//
// Each request word carries one command: a register read or write, or a
// render-timing event (coarse X or Y increment, horizontal or vertical copy,
// vblank start, prerender clear, sprite-zero hit). Each request produces
// exactly one response word with the read byte, the interrupt pulse, the
// data-port address and strobes, and the scroll, control and mask state
// after the command.
// A request is taken every cycle unless the response channel stalls. The
// response is registered in the first stage, which covers the sprite memory's
// registered read port that data-port and scroll updates ride along with,
// and then in the output register. A response stage and an output register
// sit between the channels, so a request is still accepted while one
// finished response waits; with both full and rsp_tready low, req_tready
// drops. Reset clears the register file, the pipeline valid flags and the
// sprite memory valid bits; sprite bytes not written since reset read as zero.
`include "assert_macros.svh"

module video_register_scroll_unit_top
   import vrsu_pkg::*;
#(
   parameter int SPRITE_MEM_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] command, [6:4] reg_index, [14:7] write_data, [22:15] mem_data
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] nmi_pulse, [22:9] mem_addr, [23] mem_read_strobe,
   // [24] mem_write_strobe, [40:25] scroll_addr, [43:41] fine_scroll_x,
   // [51:44] control_byte, [59:52] mask_byte
   output logic [63:0] rsp_tdata
);

   localparam int SpriteAddrBits = $clog2(SPRITE_MEM_BYTES);

   logic                      fire;
   logic [3:0]                command;
   logic [2:0]                reg_index;
   logic [7:0]                write_data;
   logic [7:0]                mem_data;
   vrsu_result_type           result;
   logic                      spr_rd_en;
   logic                      spr_wr_en;
   logic [SpriteAddrBits-1:0] spr_addr;
   logic [7:0]                spr_rd_data;
   vrsu_pipe_status_type      pipe_status;
   logic                      pipe_stalled;
   logic                      pipe_empty;
   logic                      nmi_cmd;

   assign command    = req_tdata[3:0];
   assign reg_index  = req_tdata[6:4];
   assign write_data = req_tdata[14:7];
   assign mem_data   = req_tdata[22:15];
   assign fire       = req_tvalid & req_tready;

   vrsu_reg_file #(
      .DEPTH(SPRITE_MEM_BYTES)
   ) u_reg_file (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .command    (command),
      .reg_index  (reg_index),
      .write_data (write_data),
      .mem_data   (mem_data),
      .result     (result),
      .spr_rd_en  (spr_rd_en),
      .spr_wr_en  (spr_wr_en),
      .spr_addr   (spr_addr)
   );

   vrsu_sprite_ram #(
      .DEPTH(SPRITE_MEM_BYTES)
   ) u_sprite_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (spr_rd_en),
      .rd_addr (spr_addr),
      .wr_en   (spr_wr_en),
      .wr_addr (spr_addr),
      .wr_data (write_data),
      .rd_data (spr_rd_data)
   );

   vrsu_rsp_pipe u_rsp_pipe (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .result      (result),
      .spr_rd_data (spr_rd_data),
      .in_ready    (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .status      (pipe_status)
   );

   assign pipe_stalled = pipe_status.s1_valid & rsp_tvalid & ~rsp_tready;
   assign pipe_empty   = ~rsp_tvalid & ~pipe_status.s1_valid;
   assign nmi_cmd      = (command == CMD_VBLANK_START)
                         | ((command == CMD_REG_WRITE) & (reg_index == REG_CTRL));

   `VRSU_ASSERT(a_accept_fills_stage, fire |=> pipe_status.s1_valid, "accepted word not staged")
   `VRSU_ASSERT(a_full_blocks_input, pipe_stalled |-> !req_tready, "input open while full")
   `VRSU_ASSERT(a_nmi_source, fire && result.nmi_pulse |-> nmi_cmd, "unexpected interrupt")
   `VRSU_ASSERT_ALWAYS(a_reset_empties, reset |=> pipe_empty, "pipeline not empty after reset")

endmodule
